// ===== rtl/lcpvv_pkg.sv =====
`default_nettype none
// Package for the perspective view-volume line clipper.
// Holds widths, codes, pipeline types and the divider step; depends on nothing.
package lcpvv_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int ZREG_BITS     = 17;
  localparam int T_BITS        = 32;
  localparam int NUM_BITS      = COORD_BITS + 4;
  localparam int TV_BITS       = T_BITS + 2;
  localparam int TU_BITS       = T_BITS + 1;
  localparam int MAG_BITS      = COORD_BITS + 1;
  localparam int PROD_BITS     = MAG_BITS + TU_BITS;
  localparam int NPLANE        = 6;
  localparam int NCOORD        = 3;
  localparam int NPOINT        = 2 * NCOORD;
  localparam int FRONT_Z_RESET = -655;

  typedef enum logic [1:0] {
    K_SKIP,
    K_REJECT,
    K_ENTER,
    K_LEAVE
  } kind_t;

  typedef enum logic [1:0] {
    C_DIV,
    C_BELOW,
    C_ABOVE,
    C_ONE
  } tcls_t;

  typedef struct packed {
    kind_t                kind;
    tcls_t                cls;
    logic [NUM_BITS-1:0]  rem;
    logic [NUM_BITS-1:0]  dd;
    logic [T_BITS-1:0]    q;
  } lane_t;

  typedef lane_t [NPLANE-1:0]                 lanes_t;
  typedef logic  [NPOINT-1:0][COORD_BITS-1:0] pts_t;
  typedef logic  [NPLANE-1:0][NUM_BITS-1:0]   nums_t;
  typedef logic  [NPLANE-1:0][TV_BITS-1:0]    tvs_t;
  typedef kind_t [NPLANE-1:0]                 kinds_t;

  function automatic lane_t div_step(lane_t l);
    lane_t               o;
    logic [NUM_BITS:0]   r2;
    o  = l;
    r2 = {l.rem, 1'b0};
    if (r2 >= {1'b0, l.dd}) begin
      r2    = r2 - {1'b0, l.dd};
      o.q   = {l.q[T_BITS-2:0], 1'b1};
    end else begin
      o.q   = {l.q[T_BITS-2:0], 1'b0};
    end
    o.rem = r2[NUM_BITS-1:0];
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lcpvv_in_if.sv =====
`default_nettype none
// Input channel carrying one line segment as a word.
// Depends on lcpvv_pkg for the coordinate width.
interface lcpvv_in_if;
  import lcpvv_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  start_z;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic signed [COORD_BITS-1:0]  end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/lcpvv_out_if.sv =====
`default_nettype none
// Result channel carrying the accept flag and the clipped segment as a word.
// Depends on lcpvv_pkg for the coordinate width.
interface lcpvv_out_if;
  import lcpvv_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic signed [COORD_BITS-1:0]  clipped_start_x;
  logic signed [COORD_BITS-1:0]  clipped_start_y;
  logic signed [COORD_BITS-1:0]  clipped_start_z;
  logic signed [COORD_BITS-1:0]  clipped_end_x;
  logic signed [COORD_BITS-1:0]  clipped_end_y;
  logic signed [COORD_BITS-1:0]  clipped_end_z;
  modport source (output valid, accepted, clipped_start_x, clipped_start_y,
                  clipped_start_z, clipped_end_x, clipped_end_y, clipped_end_z,
                  input ready);
  modport sink (input valid, accepted, clipped_start_x, clipped_start_y,
                clipped_start_z, clipped_end_x, clipped_end_y, clipped_end_z,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/line_clip_perspective_view_volume.sv =====
`default_nettype none
// Top level of the Liang-Barsky clipper for the perspective view volume.
// Depends on lcpvv_pkg, lcpvv_in_if and lcpvv_out_if.

// The block takes one segment word per cycle while the pipeline is not held, and
// returns one result word per segment, in order. The pipeline is formed by the
// bit-per-stage dividers that form the six plane parameters, preceded by three
// stages that register the segment, form the plane terms and set up the dividers,
// and followed by one stage that classifies the parameters, one stage per plane
// test and three stages for the end-point multiplication. The whole pipeline
// holds while a finished word waits at the output and the sink is not ready.
module line_clip_perspective_view_volume (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lcpvv_in_if.sink                            in_ch,
  lcpvv_out_if.source                         out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lcpvv_pkg::ZREG_BITS-1:0] cfg_wdata
);
  import lcpvv_pkg::*;

  logic                  adv;
  logic [ZREG_BITS-1:0]  frontz_r;

  logic                  v0_r;
  pts_t                  pt0_r;
  logic                  v1_r;
  pts_t                  pt1_r;
  nums_t                 den1_r;
  nums_t                 num1_r;
  nums_t                 den1_nxt;
  nums_t                 num1_nxt;
  lanes_t                lane0_nxt;

  logic                  dv_r  [T_BITS+1];
  pts_t                  dpt_r [T_BITS+1];
  lanes_t                dl_r  [T_BITS+1];

  logic                  pv_r  [NPLANE+1];
  pts_t                  ppt_r [NPLANE+1];
  tvs_t                  ptv_r [NPLANE+1];
  kinds_t                pk_r  [NPLANE+1];
  logic                  pok_r [NPLANE+1];
  logic [TV_BITS-1:0]    pte_r [NPLANE+1];
  logic [TV_BITS-1:0]    ptl_r [NPLANE+1];
  tvs_t                  tv_nxt;

  logic                                   m1v_r, m2v_r, ov_r;
  pts_t                                   m1pt_r, m2pt_r;
  logic [NCOORD-1:0][MAG_BITS-1:0]        mag_r;
  logic [NCOORD-1:0]                      neg1_r, neg2_r;
  logic [TU_BITS-1:0]                     te1_r, tl1_r;
  logic                                   ok1_r, ok2_r, mvs1_r, mve1_r, mvs2_r, mve2_r;
  logic [NPOINT-1:0][PROD_BITS-1:0]       prod_r;
  pts_t                                   res_nxt;
  pts_t                                   res_r;
  logic                                   acc_r;
  logic [NCOORD-1:0][MAG_BITS-1:0]        mag_nxt;
  logic [NCOORD-1:0]                      neg_nxt;

  assign adv         = !ov_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frontz_r <= ZREG_BITS'(FRONT_Z_RESET);
    end else if (cfg_we) begin
      frontz_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt0_r  <= {in_ch.end_z, in_ch.end_y, in_ch.end_x,
                 in_ch.start_z, in_ch.start_y, in_ch.start_x};
      pt1_r  <= pt0_r;
      den1_r <= den1_nxt;
      num1_r <= num1_nxt;
    end
  end

  always_comb begin
    logic signed [NUM_BITS-1:0] x0, y0, z0, x1, y1, z1, dx, dy, dz, zmin, one;
    x0   = NUM_BITS'($signed(pt0_r[0]));
    y0   = NUM_BITS'($signed(pt0_r[1]));
    z0   = NUM_BITS'($signed(pt0_r[2]));
    x1   = NUM_BITS'($signed(pt0_r[3]));
    y1   = NUM_BITS'($signed(pt0_r[4]));
    z1   = NUM_BITS'($signed(pt0_r[5]));
    zmin = NUM_BITS'($signed(frontz_r));
    one  = NUM_BITS'(1) <<< FRAC_BITS;
    dx   = x1 - x0;
    dy   = y1 - y0;
    dz   = z1 - z0;
    den1_nxt[0] = -dx - dz;  num1_nxt[0] = x0 + z0;
    den1_nxt[1] = dx - dz;   num1_nxt[1] = z0 - x0;
    den1_nxt[2] = dy - dz;   num1_nxt[2] = z0 - y0;
    den1_nxt[3] = -dy - dz;  num1_nxt[3] = y0 + z0;
    den1_nxt[4] = -dz;       num1_nxt[4] = z0 - zmin;
    den1_nxt[5] = dz;        num1_nxt[5] = -z0 - one;
  end

  always_comb begin
    logic signed [NUM_BITS-1:0] den, num, nn, dd;
    for (int j = 0; j < NPLANE; j++) begin
      den = $signed(den1_r[j]);
      num = $signed(num1_r[j]);
      nn  = (den < 0) ? -num : num;
      dd  = (den < 0) ? -den : den;
      lane0_nxt[j].q   = '0;
      lane0_nxt[j].rem = nn;
      lane0_nxt[j].dd  = dd;
      if (den == 0) begin
        lane0_nxt[j].kind = (num > 0) ? K_REJECT : K_SKIP;
      end else if (den > 0) begin
        lane0_nxt[j].kind = K_ENTER;
      end else begin
        lane0_nxt[j].kind = K_LEAVE;
      end
      if (nn < 0) begin
        lane0_nxt[j].cls = C_BELOW;
      end else if (nn > dd) begin
        lane0_nxt[j].cls = C_ABOVE;
      end else if (nn == dd) begin
        lane0_nxt[j].cls = C_ONE;
      end else begin
        lane0_nxt[j].cls = C_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dpt_r[0] <= pt1_r;
      dl_r[0]  <= lane0_nxt;
    end
  end

  for (genvar k = 0; k < T_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dpt_r[k+1] <= dpt_r[k];
        for (int j = 0; j < NPLANE; j++) begin
          dl_r[k+1][j] <= div_step(dl_r[k][j]);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NPLANE; j++) begin
      case (dl_r[T_BITS][j].cls)
        C_BELOW: tv_nxt[j] = '1;
        C_ABOVE: tv_nxt[j] = (TV_BITS'(1) << T_BITS) + TV_BITS'(1);
        C_ONE:   tv_nxt[j] = TV_BITS'(1) << T_BITS;
        default: tv_nxt[j] = TV_BITS'(dl_r[T_BITS][j].q);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else if (adv) begin
      pv_r[0] <= dv_r[T_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ppt_r[0] <= dpt_r[T_BITS];
      ptv_r[0] <= tv_nxt;
      for (int j = 0; j < NPLANE; j++) begin
        pk_r[0][j] <= dl_r[T_BITS][j].kind;
      end
      pok_r[0] <= 1'b1;
      pte_r[0] <= '0;
      ptl_r[0] <= TV_BITS'(1) << T_BITS;
    end
  end

  for (genvar p = 0; p < NPLANE; p++) begin : g_plane
    logic               ok_nxt;
    logic [TV_BITS-1:0] te_nxt, tl_nxt;

    always_comb begin
      logic signed [TV_BITS-1:0] t, te, tl;
      t      = $signed(ptv_r[p][p]);
      te     = $signed(pte_r[p]);
      tl     = $signed(ptl_r[p]);
      ok_nxt = pok_r[p];
      te_nxt = pte_r[p];
      tl_nxt = ptl_r[p];
      if (pok_r[p]) begin
        unique case (pk_r[p][p])
          K_ENTER: begin
            if (t > tl) begin
              ok_nxt = 1'b0;
            end else if (t > te) begin
              te_nxt = t;
            end
          end
          K_LEAVE: begin
            if (t < te) begin
              ok_nxt = 1'b0;
            end else if (t < tl) begin
              tl_nxt = t;
            end
          end
          K_REJECT: ok_nxt = 1'b0;
          default: ;
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[p+1] <= 1'b0;
      end else if (adv) begin
        pv_r[p+1] <= pv_r[p];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ppt_r[p+1] <= ppt_r[p];
        ptv_r[p+1] <= ptv_r[p];
        pk_r[p+1]  <= pk_r[p];
        pok_r[p+1] <= ok_nxt;
        pte_r[p+1] <= te_nxt;
        ptl_r[p+1] <= tl_nxt;
      end
    end
  end

  always_comb begin
    logic signed [MAG_BITS-1:0] d;
    for (int c = 0; c < NCOORD; c++) begin
      d = MAG_BITS'($signed(ppt_r[NPLANE][c+NCOORD])) -
          MAG_BITS'($signed(ppt_r[NPLANE][c]));
      neg_nxt[c] = d[MAG_BITS-1];
      mag_nxt[c] = d[MAG_BITS-1] ? -d : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (adv) begin
      m1v_r <= pv_r[NPLANE];
      m2v_r <= m1v_r;
      ov_r  <= m2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1pt_r <= ppt_r[NPLANE];
      mag_r  <= mag_nxt;
      neg1_r <= neg_nxt;
      te1_r  <= pte_r[NPLANE][TU_BITS-1:0];
      tl1_r  <= ptl_r[NPLANE][TU_BITS-1:0];
      ok1_r  <= pok_r[NPLANE];
      mvs1_r <= pok_r[NPLANE] && ($signed(pte_r[NPLANE]) > 0);
      mve1_r <= pok_r[NPLANE] && ($signed(ptl_r[NPLANE]) < $signed(TV_BITS'(1) << T_BITS));

      m2pt_r <= m1pt_r;
      neg2_r <= neg1_r;
      ok2_r  <= ok1_r;
      mvs2_r <= mvs1_r;
      mve2_r <= mve1_r;
      for (int c = 0; c < NCOORD; c++) begin
        prod_r[c]        <= PROD_BITS'(mag_r[c]) * PROD_BITS'(te1_r);
        prod_r[c+NCOORD] <= PROD_BITS'(mag_r[c]) * PROD_BITS'(tl1_r);
      end

      res_r <= res_nxt;
      acc_r <= ok2_r;
    end
  end

  always_comb begin
    logic [PROD_BITS-1:0]   rnd;
    logic [COORD_BITS-1:0]  step;
    logic [COORD_BITS-1:0]  moved;
    res_nxt = m2pt_r;
    for (int i = 0; i < NPOINT; i++) begin
      rnd   = prod_r[i] + (PROD_BITS'(1) << (T_BITS - 1));
      step  = rnd[T_BITS +: COORD_BITS];
      moved = neg2_r[i % NCOORD] ? m2pt_r[i % NCOORD] - step
                                 : m2pt_r[i % NCOORD] + step;
      if ((i < NCOORD) ? mvs2_r : mve2_r) begin
        res_nxt[i] = moved;
      end
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.accepted        = acc_r;
  assign out_ch.clipped_start_x = res_r[0];
  assign out_ch.clipped_start_y = res_r[1];
  assign out_ch.clipped_start_z = res_r[2];
  assign out_ch.clipped_end_x   = res_r[3];
  assign out_ch.clipped_end_y   = res_r[4];
  assign out_ch.clipped_end_z   = res_r[5];

endmodule
`default_nettype wire
